// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define OLE_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define OLE_ASSERT_IMPL(name, clk, rst, cond, cons, msg) \
   `OLE_ASSERT(name, clk, rst, (cond) |-> (cons), msg)

`endif

// ----- hw/rtl/olist_pkg.sv -----
// Shared types and constants of the ordered list engine.
package olist_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int MAX_RUN       = 16;

   localparam int OP_W   = 2;
   localparam int POS_W  = 5;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 3;
   localparam int IDX_W  = 4;
   localparam int CNT_W  = 5;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND,
      OP_INSERT,
      OP_DELETE,
      OP_READ
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK,
      STAT_FULL,
      STAT_BAD_POS,
      STAT_NOT_FOUND,
      STAT_EMPTY
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_READ
   } state_type;

   typedef enum logic [1:0] {
      ACT_HOLD,
      ACT_PLACE,
      ACT_REMOVE,
      ACT_ROTATE
   } act_type;

   typedef struct packed {
      logic    take_item;
      act_type act;
      logic    load_single;
      logic    load_entry;
      logic    idx_step;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   place_ok;
      logic   remove_ok;
      logic   list_empty;
      logic   emit;
      logic   run_last;
      logic   rot_done;
   } dp_stat_type;

endpackage

// ----- hw/rtl/olist_datapath.sv -----
// Cell chain, item registers and result register of the ordered list engine.
module olist_datapath #(
   parameter int DEPTH = olist_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  olist_pkg::op_type                req_op,
   input  logic [olist_pkg::POS_W-1:0]      req_pos,
   input  logic [olist_pkg::VAL_W-1:0]      req_val,
   input  olist_pkg::dp_cmd_type            cmd,
   output olist_pkg::dp_stat_type           stat,
   output logic [olist_pkg::STAT_W-1:0]     rsp_status,
   output logic [olist_pkg::VAL_W-1:0]      rsp_value,
   output logic [olist_pkg::IDX_W-1:0]      rsp_index,
   output logic [olist_pkg::CNT_W-1:0]      rsp_count,
   output logic                             rsp_last
);
   import olist_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   logic [VAL_W-1:0]  entries_ff [DEPTH];
   logic [VAL_W-1:0]  entries_in [DEPTH];
   logic [CW-1:0]     count_ff, count_in;
   op_type            op_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [VAL_W-1:0]  val_ff;
   logic [DEPTH-1:0]  match_ff, match_in;
   logic [CW-1:0]     idx_ff, idx_in;

   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [PW-1:0]     pos_w, cnt_w, idx_w, run_n;
   logic              full, bad_pos, found;
   logic [IW-1:0]     place_at;
   logic [DEPTH-1:0]  first_hit, from_hit;
   logic [CW-1:0]     tail_at;
   status_type        single_st;

   // Flags and item status
   always_comb begin
      pos_w     = PW'(pos_ff);
      cnt_w     = PW'(count_ff);
      idx_w     = PW'(idx_ff);
      full      = (cnt_w >= PW'(DEPTH));
      bad_pos   = (pos_w > cnt_w);
      found     = |match_ff;
      run_n     = (cnt_w > PW'(MAX_RUN)) ? PW'(MAX_RUN) : cnt_w;
      place_at  = (op_ff == OP_APPEND) ? IW'(count_ff) : IW'(pos_ff);
      // lowest matching cell, and every cell from it up
      first_hit = match_ff & (~match_ff + DEPTH'(1));
      from_hit  = ~(first_hit - DEPTH'(1));
      tail_at   = count_ff - CW'(1);

      stat.op         = op_ff;
      stat.place_ok   = ((op_ff == OP_APPEND) || ((op_ff == OP_INSERT) && !bad_pos)) && !full;
      stat.remove_ok  = (op_ff == OP_DELETE) && found;
      stat.list_empty = (count_ff == '0);
      stat.emit       = (idx_w < PW'(MAX_RUN));
      stat.run_last   = (idx_w == run_n - PW'(1));
      stat.rot_done   = (idx_w == cnt_w - PW'(1));

      case (op_ff)
         OP_APPEND: single_st = full ? STAT_FULL : STAT_OK;
         OP_INSERT: single_st = bad_pos ? STAT_BAD_POS : (full ? STAT_FULL : STAT_OK);
         OP_DELETE: single_st = found ? STAT_OK : STAT_NOT_FOUND;
         default:   single_st = STAT_EMPTY;
      endcase
   end

   // Cell chain, match flags, read index and result register next state
   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      case (cmd.act)
         ACT_PLACE: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (IW'(i) == place_at) entries_in[i] = val_ff;
            end
            for (int i = 1; i < DEPTH; i++) begin
               if (IW'(i) > place_at) entries_in[i] = entries_ff[i-1];
            end
            count_in = count_ff + CW'(1);
         end
         ACT_REMOVE: begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               if (from_hit[i]) entries_in[i] = entries_ff[i+1];
            end
            count_in = count_ff - CW'(1);
         end
         ACT_ROTATE: begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               if (CW'(i) < tail_at) entries_in[i] = entries_ff[i+1];
            end
            for (int i = 0; i < DEPTH; i++) begin
               if (CW'(i) == tail_at) entries_in[i] = entries_ff[0];
            end
         end
         default: begin
         end
      endcase

      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (entries_ff[i] == req_val) && (CW'(i) < count_ff);
      end

      idx_in = idx_ff;
      if (cmd.take_item) begin
         idx_in = '0;
      end else if (cmd.idx_step) begin
         idx_in = idx_ff + CW'(1);
      end

      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.load_single) begin
         rsp_status_in = single_st;
         rsp_value_in  = '0;
         rsp_index_in  = '0;
         rsp_count_in  = CNT_W'(count_in);
         rsp_last_in   = 1'b1;
      end else if (cmd.load_entry) begin
         rsp_status_in = STAT_OK;
         rsp_value_in  = entries_ff[0];
         rsp_index_in  = IDX_W'(idx_ff);
         rsp_count_in  = CNT_W'(count_ff);
         rsp_last_in   = stat.run_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff    <= entries_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      if (cmd.take_item) begin
         op_ff    <= req_op;
         pos_ff   <= req_pos;
         val_ff   <= req_val;
         match_ff <= match_in;
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ----- hw/rtl/olist_ctrl.sv -----
// Controller state machine and result valid flag of the ordered list engine.
module olist_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  olist_pkg::dp_stat_type stat,
   output olist_pkg::dp_cmd_type  cmd
);
   import olist_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free        = !rsp_valid_ff || rsp_tready;
      state_in        = state_ff;
      req_tready      = 1'b0;
      cmd.take_item   = 1'b0;
      cmd.act         = ACT_HOLD;
      cmd.load_single = 1'b0;
      cmd.load_entry  = 1'b0;
      cmd.idx_step    = 1'b0;

      case (state_ff)
         FSM_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take_item = 1'b1;
               state_in      = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if ((stat.op == OP_READ) && !stat.list_empty) begin
               state_in = FSM_READ;
            end else if (out_free) begin
               cmd.load_single = 1'b1;
               if (stat.place_ok) begin
                  cmd.act = ACT_PLACE;
               end else if (stat.remove_ok) begin
                  cmd.act = ACT_REMOVE;
               end
               state_in = FSM_IDLE;
            end
         end
         FSM_READ: begin
            // past the run limit, rotate silently to restore the order
            if (!stat.emit || out_free) begin
               cmd.act        = ACT_ROTATE;
               cmd.idx_step   = 1'b1;
               cmd.load_entry = stat.emit;
               if (stat.rot_done) state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      if (cmd.load_single || cmd.load_entry) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- hw/rtl/ordered_list_engine.sv -----
// Top level of the ordered list engine: bounded ordered list of signed values.
//
//   channel | direction | payload
//   req_    | in        | tdata: operation, position, value
//   rsp_    | out       | tdata: status, entry_value, entry_index, entry_count; tlast
//
// Append, insert and delete take the beat and compare every cell against the
// value, then shift the cell chain and load the result register once it is
// free. A read-out takes the beat and tests for an empty list; then the chain
// rotates one cell per cycle while the result register is free or the run limit
// is passed, and the head cell feeds the result register. An empty read-out loads its status on the test.
// Reset clears the entry count, the controller state and the result valid flag;
// entry storage is not cleared.
// A result waiting in the result register holds the controller before its next
// load; the input stays stalled until the item's last result is loaded.
module ordered_list_engine #(
   parameter int DEPTH = olist_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // operation[1:0], position[6:2], value[38:7], zero fill above
   input  logic [olist_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status[2:0], entry_value[34:3], entry_index[38:35], entry_count[43:39], zero fill
   output logic [olist_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast
);
   import olist_pkg::*;

`include "assert_macros.svh"

   localparam int RSP_USED_W = STAT_W + VAL_W + IDX_W + CNT_W;

   dp_cmd_type        cmd;
   dp_stat_type       stat;
   op_type            req_op;
   logic [POS_W-1:0]  req_pos;
   logic [VAL_W-1:0]  req_val;
   logic [STAT_W-1:0] rsp_status;
   logic [VAL_W-1:0]  rsp_value;
   logic [IDX_W-1:0]  rsp_index;
   logic [CNT_W-1:0]  rsp_count;

   // Unpack the request beat
   assign req_op  = op_type'(req_tdata[OP_W-1:0]);
   assign req_pos = req_tdata[OP_W +: POS_W];
   assign req_val = req_tdata[OP_W + POS_W +: VAL_W];

   olist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   olist_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_op),
      .req_pos    (req_pos),
      .req_val    (req_val),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_status (rsp_status),
      .rsp_value  (rsp_value),
      .rsp_index  (rsp_index),
      .rsp_count  (rsp_count),
      .rsp_last   (rsp_tlast)
   );

   // Pack the result beat, first field lowest
   assign rsp_tdata = {{(RSP_DATA_W - RSP_USED_W){1'b0}},
                       rsp_count, rsp_index, rsp_value, rsp_status};

   // Hold off new items while one is in flight
`OLE_ASSERT(a_one_item_in_flight, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "item accepted while busy")

   // Load the result register only when it is free or being drained
`OLE_ASSERT_IMPL(a_load_free, clock, reset, cmd.load_single || cmd.load_entry, !rsp_tvalid || rsp_tready, "result overwritten")

   // Nothing but the last beat of a run may carry an error status
`OLE_ASSERT_IMPL(a_mid_run_ok, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tdata[STAT_W-1:0] == STAT_OK, "bad status inside read-out")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the ordered list engine: directed and random stream traffic against a list model.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import olist_pkg::*;

   localparam int LIST_DEPTH   = DEPTH_DEFAULT;
   localparam int STALL_LIMIT  = 5000;   // cycles without any beat before giving up
   localparam int DRAIN_CYCLES = 40;     // settle time after the last reply
   localparam int RANDOM_ITEMS = 400;

   // One request beat as the list sees it.
   typedef struct {
      op_type      op;
      logic [4:0]  pos;
      logic [31:0] val;
   } list_cmd_type;

   // One reply beat, field by field.
   typedef struct packed {
      status_type  st;
      logic [31:0] val;
      logic [3:0]  idx;
      logic [4:0]  cnt;
      logic        last;
   } list_reply_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   ordered_list_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Commands waiting to be driven, and replies the list model says are due.
   list_cmd_type   cmd_backlog[$];
   list_reply_type reply_due[$];

   // Shadow of the list contents.
   logic [31:0] list_mem[LIST_DEPTH];
   int          list_len = 0;

   // Values of the last 32 queued appends and inserts; deletes draw from here to hit.
   logic [31:0] seen_vals[$];

   int items_total  = 0;
   int items_taken  = 0;
   int reads_taken  = 0;
   int beats_seen   = 0;
   int fail_count   = 0;
   int full_seen    = 0;
   int badpos_seen  = 0;
   int miss_seen    = 0;
   int quiet_cycles = 0;

   list_cmd_type in_flight;

   // Hold both sides busy-free through a stretch in the middle of the run.
   logic calm;
   assign calm = (items_taken >= 200) && (items_taken < 300);

   // Apply one accepted command to the shadow list and queue the replies it causes.
   task automatic list_apply(input list_cmd_type c);
      list_reply_type r;
      int             hit;
      int             n;
      r = '{st: STAT_OK, val: '0, idx: '0, cnt: '0, last: 1'b1};
      hit = -1;
      case (c.op)
         OP_APPEND: begin
            if (list_len >= LIST_DEPTH) begin
               r.st = STAT_FULL;
            end else begin
               list_mem[list_len] = c.val;
               list_len++;
            end
         end
         OP_INSERT: begin
            // position is checked before fullness
            if (int'(c.pos) > list_len) begin
               r.st = STAT_BAD_POS;
            end else if (list_len >= LIST_DEPTH) begin
               r.st = STAT_FULL;
            end else begin
               for (int i = list_len; i > int'(c.pos); i--) list_mem[i] = list_mem[i-1];
               list_mem[c.pos] = c.val;
               list_len++;
            end
         end
         OP_DELETE: begin
            for (int i = 0; i < list_len; i++)
               if (hit < 0 && list_mem[i] == c.val) hit = i;
            if (hit < 0) begin
               r.st = STAT_NOT_FOUND;
            end else begin
               for (int i = hit; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
            end
         end
         default: begin
            if (list_len == 0) begin
               r.st  = STAT_EMPTY;
               r.cnt = '0;
               reply_due.push_back(r);
            end else begin
               n = (list_len > MAX_RUN) ? MAX_RUN : list_len;
               for (int i = 0; i < n; i++) begin
                  r.val  = list_mem[i];
                  r.idx  = 4'(i);
                  r.cnt  = 5'(list_len);
                  r.last = (i + 1 == n);
                  reply_due.push_back(r);
               end
            end
         end
      endcase
      if (c.op != OP_READ) begin
         r.cnt = 5'(list_len);
         reply_due.push_back(r);
      end
   endtask

   task automatic push_cmd(input op_type op, input logic [4:0] pos, input logic [31:0] val);
      list_cmd_type c;
      c.op  = op;
      c.pos = pos;
      c.val = val;
      cmd_backlog.push_back(c);
      if (op == OP_APPEND || op == OP_INSERT) begin
         seen_vals.push_back(val);
         if (seen_vals.size() > 32) void'(seen_vals.pop_front());
      end
   endtask

   function automatic logic [31:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return 32'($signed($urandom_range(0, 4)) - 2);
      if (roll < 35) return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return $urandom;
   endfunction

   function automatic logic [4:0] pick_pos();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 5'($urandom_range(0, 4));
      if (roll < 92) return 5'($urandom_range(0, 16));
      return 5'($urandom_range(17, 31));
   endfunction

   task automatic build_stimulus();
      int          roll;
      int          mode;
      logic [31:0] v;
      // Directed opening: empty list corners, shifting, full list, bad positions.
      push_cmd(OP_READ,   5'd0,  32'd0);          // read-out of an empty list
      push_cmd(OP_DELETE, 5'd0,  32'd0);          // delete on an empty list
      push_cmd(OP_INSERT, 5'd1,  32'd3);          // beyond count on empty list
      push_cmd(OP_INSERT, 5'd0,  32'd7);          // empty list at position zero
      push_cmd(OP_DELETE, 5'd0,  32'd7);          // delete of the only entry
      push_cmd(OP_INSERT, 5'd0,  32'h8000_0000);
      push_cmd(OP_INSERT, 5'd1,  32'h7FFF_FFFF);  // position equal to count appends
      push_cmd(OP_INSERT, 5'd0,  32'hFFFF_FFFF);
      push_cmd(OP_APPEND, 5'd31, 32'd0);
      push_cmd(OP_APPEND, 5'd0,  32'hFFFF_FFFF);  // duplicate for first-equal delete
      push_cmd(OP_APPEND, 5'd0,  32'h5555_5555);
      push_cmd(OP_APPEND, 5'd0,  32'hAAAA_AAAA);
      for (int i = 0; i < 9; i++) push_cmd(OP_APPEND, 5'($urandom), $urandom);
      push_cmd(OP_APPEND, 5'd0,  32'd1);          // append when full
      push_cmd(OP_INSERT, 5'd3,  32'd2);          // insert when full at valid position
      push_cmd(OP_INSERT, 5'd17, 32'd2);          // bad position wins over full
      push_cmd(OP_INSERT, 5'd31, 32'd2);
      push_cmd(OP_READ,   5'd31, $urandom);       // sixteen-beat read-out
      push_cmd(OP_DELETE, 5'd0,  32'hFFFF_FFFF);  // removes the first of two
      push_cmd(OP_DELETE, 5'd0,  32'h0BAD_F00D);
      push_cmd(OP_READ,   5'd0,  32'd0);

      // Random part in phases that grow, drain or churn the list.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         mode = (i / 40) % 3;
         roll = $urandom_range(0, 99);
         if (mode == 0) begin
            if (roll < 40)      push_cmd(OP_APPEND, pick_pos(), pick_value());
            else if (roll < 80) push_cmd(OP_INSERT, pick_pos(), pick_value());
            else if (roll < 90) roll = 200;
            else                push_cmd(OP_READ, 5'($urandom), $urandom);
         end else if (mode == 1) begin
            if (roll < 70)      roll = 200;
            else if (roll < 80) push_cmd(OP_READ, 5'($urandom), $urandom);
            else if (roll < 90) push_cmd(OP_INSERT, pick_pos(), pick_value());
            else                push_cmd(OP_APPEND, pick_pos(), pick_value());
         end else begin
            if (roll < 25)      push_cmd(OP_APPEND, pick_pos(), pick_value());
            else if (roll < 50) push_cmd(OP_INSERT, pick_pos(), pick_value());
            else if (roll < 80) roll = 200;
            else                push_cmd(OP_READ, 5'($urandom), $urandom);
         end
         if (roll == 200) begin
            // aim most deletes at values of recent appends and inserts
            if (seen_vals.size() != 0 && $urandom_range(0, 99) < 75)
               v = seen_vals[$urandom_range(0, seen_vals.size() - 1)];
            else
               v = pick_value();
            push_cmd(OP_DELETE, 5'($urandom), v);
         end
      end
   endtask

   // Driver: present the next command, hold it until accepted, idle at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            list_apply(in_flight);
            items_taken++;
            if (in_flight.op == OP_READ) reads_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
               in_flight = cmd_backlog.pop_front();
               req_tdata  <= {1'b0, in_flight.val, in_flight.pos, in_flight.op};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random, compare each reply beat with the oldest due one.
   always @(posedge clock) begin
      list_reply_type got;
      list_reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            beats_seen++;
            got.st   = status_type'(rsp_tdata[2:0]);
            got.val  = rsp_tdata[34:3];
            got.idx  = rsp_tdata[38:35];
            got.cnt  = rsp_tdata[43:39];
            got.last = rsp_tlast;
            case (got.st)
               STAT_FULL:      full_seen++;
               STAT_BAD_POS:   badpos_seen++;
               STAT_NOT_FOUND: miss_seen++;
               default: ;
            endcase
            if (reply_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected reply beat status=%0d value=%h index=%0d count=%0d last=%b",
                        $time, got.st, got.val, got.idx, got.cnt, got.last);
            end else begin
               want = reply_due.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display("%0t: reply mismatch", $time);
                  $display("   expected status=%0d value=%h index=%0d count=%0d last=%b",
                           want.st, want.val, want.idx, want.cnt, want.last);
                  $display("   actual   status=%0d value=%h index=%0d count=%0d last=%b",
                           got.st, got.val, got.idx, got.cnt, got.last);
               end
            end
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= 33);
      end
   end

   // Watchdog: end the run if no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d replies outstanding",
                  $time, STALL_LIMIT, reply_due.size());
         $display("ordered_list_engine verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      build_stimulus();
      items_total = cmd_backlog.size();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // drain: every command taken and every reply back
      while (items_taken < items_total || reply_due.size() != 0) @(posedge clock);
      // catch stray beats after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d commands (%0d read-outs) and %0d reply beats",
               items_taken, reads_taken, beats_seen);
      $display("replies seen: %0d full, %0d bad position, %0d not found",
               full_seen, badpos_seen, miss_seen);
      if (fail_count == 0) begin
         $display("ordered_list_engine verification clean");
      end else begin
         $display("ordered_list_engine verification failed");
      end
      $finish;
   end

endmodule
